// ===== hdl/erbs_pkg.sv =====
// Shared types, register indexes and the control program of the spawner.
// Used by erbs_seq, erbs_dp and emission_rate_burst_spawner_unit.
package erbs_pkg;

  localparam int STEP_W = 4;
  localparam int DIV_STEPS = 40;
  localparam int DIV_CNT_W = 6;

  localparam logic [1:0] REG_EMISSION_RATE = 2'd0;
  localparam logic [1:0] REG_BURST_COUNT = 2'd1;
  localparam logic [1:0] REG_BURST_INTERVAL = 2'd2;

  typedef struct packed {
    logic [23:0] tick_dt;
    logic [10:0] free_slots;
  } erbs_in_t;

  typedef struct packed {
    logic [10:0] rate_spawns;
    logic [10:0] burst_spawns;
    logic [10:0] spawn_total;
    logic pool_full;
  } erbs_out_t;

  typedef struct packed {
    logic [31:0] emission_rate;
    logic [10:0] burst_count;
    logic [23:0] burst_interval;
  } erbs_cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_ACC,
    OP_RGRANT,
    OP_FIRST,
    OP_TADD,
    OP_DIV,
    OP_BMUL,
    OP_BGRANT,
    OP_OUT
  } erbs_op_t;

  typedef enum logic [2:0] {
    COND_ADVANCE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SKIP_BURST,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } erbs_cond_t;

  typedef struct packed {
    erbs_op_t op;
    erbs_cond_t cond;
    logic [STEP_W-1:0] target;
  } erbs_cw_t;

  typedef struct packed {
    logic in_valid;
    logic skip_burst;
    logic div_more;
    logic out_busy;
  } erbs_status_t;

  localparam logic [STEP_W-1:0] STEP_LOAD = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIV = 4'd6;
  localparam logic [STEP_W-1:0] STEP_OUT = 4'd9;

  function automatic erbs_cw_t ucode(input logic [STEP_W-1:0] step);
    erbs_cw_t cw;
    cw = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD};
    case (step)
      4'd0: cw = '{op: OP_LOAD, cond: COND_NO_INPUT, target: STEP_LOAD};
      4'd1: cw = '{op: OP_MUL, cond: COND_ADVANCE, target: STEP_LOAD};
      4'd2: cw = '{op: OP_ACC, cond: COND_ADVANCE, target: STEP_LOAD};
      4'd3: cw = '{op: OP_RGRANT, cond: COND_ADVANCE, target: STEP_LOAD};
      4'd4: cw = '{op: OP_FIRST, cond: COND_SKIP_BURST, target: STEP_OUT};
      4'd5: cw = '{op: OP_TADD, cond: COND_ADVANCE, target: STEP_LOAD};
      4'd6: cw = '{op: OP_DIV, cond: COND_DIV_MORE, target: STEP_DIV};
      4'd7: cw = '{op: OP_BMUL, cond: COND_ADVANCE, target: STEP_LOAD};
      4'd8: cw = '{op: OP_BGRANT, cond: COND_ADVANCE, target: STEP_LOAD};
      4'd9: cw = '{op: OP_OUT, cond: COND_OUT_BUSY, target: STEP_OUT};
      4'd10: cw = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD};
      default: cw = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/erbs_seq.sv =====
// Step counter and control store of the spawner.
// Depends on erbs_pkg for the control word, status and program.
module erbs_seq (
  input  logic clk,
  input  logic rst,
  input  erbs_pkg::erbs_status_t status,
  output erbs_pkg::erbs_cw_t ctrl
);

  logic [erbs_pkg::STEP_W-1:0] step;
  logic [erbs_pkg::STEP_W-1:0] step_next;
  logic [erbs_pkg::STEP_W-1:0] step_inc;
  erbs_pkg::erbs_cw_t cw;

  always_comb begin
    cw = erbs_pkg::ucode(step);
    step_inc = step + erbs_pkg::STEP_W'(1);
  end

  always_comb begin
    case (cw.cond)
      erbs_pkg::COND_ADVANCE: step_next = step_inc;
      erbs_pkg::COND_ALWAYS: step_next = cw.target;
      erbs_pkg::COND_NO_INPUT: step_next = status.in_valid ? step_inc : cw.target;
      erbs_pkg::COND_SKIP_BURST: step_next = status.skip_burst ? cw.target : step_inc;
      erbs_pkg::COND_DIV_MORE: step_next = status.div_more ? cw.target : step_inc;
      erbs_pkg::COND_OUT_BUSY: step_next = status.out_busy ? cw.target : step_inc;
      default: step_next = erbs_pkg::STEP_LOAD;
    endcase
  end

  always_comb begin
    ctrl = cw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= erbs_pkg::STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== hdl/erbs_dp.sv =====
// Datapath of the spawner: accumulator, burst timer, radix-2 divider,
// slot grants and output register. Driven by erbs_seq; types from erbs_pkg.
module erbs_dp #(
  parameter int POOL_SLOTS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  erbs_pkg::erbs_cw_t ctrl,
  input  erbs_pkg::erbs_cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  erbs_pkg::erbs_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output erbs_pkg::erbs_out_t out_data,
  output erbs_pkg::erbs_status_t status
);

  localparam logic [31:0] POOL_LIMIT = 32'(POOL_SLOTS);

  logic [23:0] dt;
  logic [10:0] avail;
  logic [10:0] avail0;
  logic [39:0] prod;
  logic [47:0] rate_accumulator;
  logic [39:0] burst_timer;
  logic first_burst_done;
  logic [39:0] quot;
  logic [23:0] rem;
  logic [erbs_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [21:0] bprod;
  logic bbig;
  logic [10:0] rate_n;
  logic [10:0] burst_n;
  logic refused;

  logic [10:0] slots_in;
  logic [48:0] acc_sum;
  logic [47:0] acc_sat;
  logic [31:0] whole;
  logic rate_lack;
  logic first_lack;
  logic [40:0] timer_sum;
  logic [39:0] timer_sat;
  logic [24:0] rem_shift;
  logic [24:0] rem_sub;
  logic rem_ge;
  logic [23:0] rem_new;
  logic burst_lack;
  logic out_busy;

  always_comb begin
    if ({21'd0, in_data.free_slots} > POOL_LIMIT) begin
      slots_in = POOL_LIMIT[10:0];
    end else begin
      slots_in = in_data.free_slots;
    end
    acc_sum = {1'b0, rate_accumulator} + {9'd0, prod};
    acc_sat = acc_sum[48] ? '1 : acc_sum[47:0];
    whole = rate_accumulator[47:16];
    rate_lack = whole > {21'd0, avail};
    first_lack = cfg.burst_count > avail;
    timer_sum = {1'b0, burst_timer} + {17'd0, dt};
    timer_sat = timer_sum[40] ? '1 : timer_sum[39:0];
    rem_shift = {rem, quot[39]};
    rem_sub = rem_shift - {1'b0, cfg.burst_interval};
    rem_ge = rem_shift >= {1'b0, cfg.burst_interval};
    rem_new = rem_ge ? rem_sub[23:0] : rem_shift[23:0];
    burst_lack = bbig || (bprod > {11'd0, avail});
    out_busy = out_valid && !out_ready;
  end

  always_comb begin
    in_ready = (ctrl.op == erbs_pkg::OP_LOAD);
    status.in_valid = in_valid;
    status.skip_burst = (cfg.burst_count == 11'd0) || !first_burst_done ||
                        (cfg.burst_interval == 24'd0);
    status.div_more = (div_cnt != '0);
    status.out_busy = out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_accumulator <= '0;
      burst_timer <= '0;
      first_burst_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (ctrl.op)
        erbs_pkg::OP_ACC: begin
          if (cfg.emission_rate != 32'd0) begin
            rate_accumulator <= acc_sat;
          end
        end
        erbs_pkg::OP_RGRANT: begin
          if (cfg.emission_rate != 32'd0 && whole != 32'd0) begin
            if (rate_lack) begin
              rate_accumulator <= '0;
            end else begin
              rate_accumulator <= {32'd0, rate_accumulator[15:0]};
            end
          end
        end
        erbs_pkg::OP_FIRST: begin
          if (cfg.burst_count != 11'd0 && !first_burst_done) begin
            first_burst_done <= 1'b1;
            burst_timer <= '0;
          end
        end
        erbs_pkg::OP_BMUL: begin
          burst_timer <= {16'd0, rem};
        end
        default: begin
        end
      endcase
      if (ctrl.op == erbs_pkg::OP_OUT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      erbs_pkg::OP_LOAD: begin
        dt <= in_data.tick_dt;
        avail <= slots_in;
        avail0 <= slots_in;
        rate_n <= '0;
        burst_n <= '0;
        refused <= 1'b0;
      end
      erbs_pkg::OP_MUL: begin
        prod <= 40'(({24'd0, cfg.emission_rate} * {32'd0, dt}) >> 16);
      end
      erbs_pkg::OP_RGRANT: begin
        if (cfg.emission_rate != 32'd0 && whole != 32'd0) begin
          if (rate_lack) begin
            rate_n <= avail;
            avail <= '0;
            refused <= 1'b1;
          end else begin
            rate_n <= whole[10:0];
            avail <= avail - whole[10:0];
          end
        end
      end
      erbs_pkg::OP_FIRST: begin
        if (cfg.burst_count != 11'd0 && !first_burst_done) begin
          if (first_lack) begin
            burst_n <= avail;
            avail <= '0;
            refused <= 1'b1;
          end else begin
            burst_n <= cfg.burst_count;
            avail <= avail - cfg.burst_count;
          end
        end
      end
      erbs_pkg::OP_TADD: begin
        quot <= timer_sat;
        rem <= '0;
        div_cnt <= erbs_pkg::DIV_CNT_W'(erbs_pkg::DIV_STEPS - 1);
      end
      erbs_pkg::OP_DIV: begin
        rem <= rem_new;
        quot <= {quot[38:0], rem_ge};
        div_cnt <= div_cnt - erbs_pkg::DIV_CNT_W'(1);
      end
      erbs_pkg::OP_BMUL: begin
        bbig <= (quot[39:11] != 29'd0);
        bprod <= {11'd0, quot[10:0]} * {11'd0, cfg.burst_count};
      end
      erbs_pkg::OP_BGRANT: begin
        if (burst_lack) begin
          burst_n <= avail;
          avail <= '0;
          refused <= 1'b1;
        end else begin
          burst_n <= bprod[10:0];
          avail <= avail - bprod[10:0];
        end
      end
      erbs_pkg::OP_OUT: begin
        if (!out_busy) begin
          out_data.rate_spawns <= rate_n;
          out_data.burst_spawns <= burst_n;
          out_data.spawn_total <= rate_n + burst_n;
          out_data.pool_full <= refused;
        end
      end
      default: begin
      end
    endcase
  end

  a_grant_fits: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == erbs_pkg::OP_OUT) |-> ({1'b0, rate_n} + {1'b0, burst_n} <= {1'b0, avail0}))
    else $error("granted spawns exceed free slots");

  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == erbs_pkg::OP_OUT && refused) |-> (avail == 11'd0))
    else $error("refusal with slots left");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == erbs_pkg::OP_BMUL) |-> (rem < cfg.burst_interval))
    else $error("divider remainder not below interval");

endmodule

// ===== hdl/emission_rate_burst_spawner_unit.sv =====
// Top level of the emission rate and burst spawner: configuration registers,
// control sequencer and datapath. Depends on erbs_pkg, erbs_seq and erbs_dp.
//
// One transaction on the input is one simulation tick; it yields exactly one
// result transaction. A tick runs the divider only when an interval burst is due
// to be evaluated: the interval count comes from a radix-2 restoring divider that
// retires one quotient bit per cycle over 40 bits. The next tick is taken once
// the result sits in the output register, so it may wait while a previous result
// is still untaken. Write configuration only while no tick is in progress.
module emission_rate_burst_spawner_unit #(
  parameter int POOL_SLOTS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  erbs_pkg::erbs_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output erbs_pkg::erbs_out_t out_data
);

  erbs_pkg::erbs_cfg_t cfg;
  erbs_pkg::erbs_cw_t ctrl;
  erbs_pkg::erbs_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        erbs_pkg::REG_EMISSION_RATE: cfg.emission_rate <= cfg_data;
        erbs_pkg::REG_BURST_COUNT: cfg.burst_count <= cfg_data[10:0];
        erbs_pkg::REG_BURST_INTERVAL: cfg.burst_interval <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  erbs_seq u_seq (
    .clk(clk),
    .rst(rst),
    .status(status),
    .ctrl(ctrl)
  );

  erbs_dp #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .cfg(cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .status(status)
  );

endmodule

// ===== tb/spawn_grant_checker.sv =====
// Checker for the emission rate and burst spawner: mirrors the registers, predicts
// the spawn grant of each tick and compares it with the result channel.
// Depends on erbs_pkg.
module spawn_grant_checker #(
  parameter int POOL_SLOTS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  input  logic in_ready,
  input  erbs_pkg::erbs_in_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  erbs_pkg::erbs_out_t out_data,
  output int fail_count,
  output int outstanding,
  output int checked
);

  localparam logic [63:0] ACC_LIMIT = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] TIMER_LIMIT = (64'd1 << 40) - 64'd1;

  logic [31:0] rate_reg;
  logic [10:0] count_reg;
  logic [23:0] interval_reg;

  logic [47:0] rate_acc;
  logic [39:0] burst_timer;
  logic first_fired;

  erbs_pkg::erbs_out_t pending_grants[$];

  function automatic erbs_pkg::erbs_out_t grant_for_tick(input erbs_pkg::erbs_in_t tick);
    logic [63:0] avail;
    logic [63:0] prod;
    logic [63:0] acc;
    logic [63:0] whole;
    logic [63:0] tmr;
    logic [63:0] bursts;
    logic [63:0] want;
    logic [63:0] rate_n;
    logic [63:0] burst_n;
    logic [63:0] total;
    logic refused;
    erbs_pkg::erbs_out_t res;
    avail = 64'(tick.free_slots);
    if (avail > 64'(POOL_SLOTS)) avail = 64'(POOL_SLOTS);
    rate_n = '0;
    burst_n = '0;
    want = '0;
    refused = 1'b0;
    if (rate_reg != '0) begin
      prod = (64'(rate_reg) * 64'(tick.tick_dt)) >> 16;
      acc = 64'(rate_acc) + prod;
      if (acc > ACC_LIMIT) acc = ACC_LIMIT;
      whole = acc >> 16;
      if (whole != '0) begin
        if (whole > avail) begin
          rate_n = avail;
          refused = 1'b1;
          acc = '0;
        end else begin
          rate_n = whole;
          acc = acc & 64'hFFFF;
        end
        avail = avail - rate_n;
      end
      rate_acc = acc[47:0];
    end
    if (count_reg != '0) begin
      if (!first_fired) begin
        want = 64'(count_reg);
        first_fired = 1'b1;
        burst_timer = '0;
      end else if (interval_reg != '0) begin
        tmr = 64'(burst_timer) + 64'(tick.tick_dt);
        if (tmr > TIMER_LIMIT) tmr = TIMER_LIMIT;
        bursts = tmr / 64'(interval_reg);
        tmr = tmr % 64'(interval_reg);
        burst_timer = tmr[39:0];
        want = bursts * 64'(count_reg);
      end
      if (want > avail) begin
        burst_n = avail;
        refused = 1'b1;
      end else begin
        burst_n = want;
      end
    end
    total = rate_n + burst_n;
    res.rate_spawns = rate_n[10:0];
    res.burst_spawns = burst_n[10:0];
    res.spawn_total = total[10:0];
    res.pool_full = refused;
    return res;
  endfunction

  always @(posedge clk) begin : track
    erbs_pkg::erbs_out_t want_res;
    logic mismatch;
    if (rst) begin
      rate_reg = '0;
      count_reg = '0;
      interval_reg = '0;
      rate_acc = '0;
      burst_timer = '0;
      first_fired = 1'b0;
      pending_grants.delete();
      fail_count = 0;
      checked = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          erbs_pkg::REG_EMISSION_RATE: rate_reg = cfg_data;
          erbs_pkg::REG_BURST_COUNT: count_reg = cfg_data[10:0];
          erbs_pkg::REG_BURST_INTERVAL: interval_reg = cfg_data[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_grants.size() == 0) begin
          $error("unexpected result transaction: rate_spawns %0d burst_spawns %0d",
                 out_data.rate_spawns, out_data.burst_spawns);
          fail_count++;
        end else begin
          want_res = pending_grants.pop_front();
          mismatch = 1'b0;
          if (out_data.rate_spawns !== want_res.rate_spawns) begin
            $error("rate_spawns: expected %0d, got %0d",
                   want_res.rate_spawns, out_data.rate_spawns);
            mismatch = 1'b1;
          end
          if (out_data.burst_spawns !== want_res.burst_spawns) begin
            $error("burst_spawns: expected %0d, got %0d",
                   want_res.burst_spawns, out_data.burst_spawns);
            mismatch = 1'b1;
          end
          if (out_data.spawn_total !== want_res.spawn_total) begin
            $error("spawn_total: expected %0d, got %0d",
                   want_res.spawn_total, out_data.spawn_total);
            mismatch = 1'b1;
          end
          if (out_data.pool_full !== want_res.pool_full) begin
            $error("pool_full: expected %0d, got %0d",
                   want_res.pool_full, out_data.pool_full);
            mismatch = 1'b1;
          end
          if (mismatch) fail_count++;
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        pending_grants.push_back(grant_for_tick(in_data));
      end
      outstanding <= pending_grants.size();
    end
  end

endmodule

// ===== tb/emission_rate_burst_spawner_unit_tb.sv =====
// Testbench top for emission_rate_burst_spawner_unit: drives ticks, register
// writes and output back-pressure, and reports the verdict.
// Depends on erbs_pkg, spawn_grant_checker and the block itself.
module emission_rate_burst_spawner_unit_tb;

  localparam int POOL_SLOTS = 1024;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD = 400;
  localparam int RAND_PHASES = 8;
  localparam int RAND_TICKS = 210;
  localparam int WATCHDOG_CYCLES = 1000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  erbs_pkg::erbs_in_t in_data;
  logic out_valid;
  logic out_ready;
  erbs_pkg::erbs_out_t out_data;

  int fail_count;
  int outstanding;
  int checked;

  logic idle_on;
  int hold_req;
  int tick_total;
  int setting_total;

  emission_rate_burst_spawner_unit #(
    .POOL_SLOTS(POOL_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  spawn_grant_checker #(
    .POOL_SLOTS(POOL_SLOTS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .fail_count(fail_count),
    .outstanding(outstanding),
    .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_CYCLES * 10);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic set_config(input logic [31:0] rate, input logic [10:0] count,
                            input logic [23:0] interval);
    cfg_we <= 1'b1;
    cfg_index <= erbs_pkg::REG_EMISSION_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_index <= erbs_pkg::REG_BURST_COUNT;
    cfg_data <= 32'(count);
    @(posedge clk);
    cfg_index <= erbs_pkg::REG_BURST_INTERVAL;
    cfg_data <= 32'(interval);
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_total++;
  endtask

  task automatic send_tick(input logic [23:0] dt, input logic [10:0] free);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{tick_dt: dt, free_slots: free};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tick_total++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int wait_cycles;
    int holds_done;
    out_ready = 1'b0;
    holds_done = 0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req != holds_done) begin
        wait_cycles = LONG_HOLD;
        holds_done++;
      end else begin
        wait_cycles = idle_on ? $urandom_range(0, 17) : 0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] rate;
    logic [10:0] count;
    logic [23:0] interval;
    logic [23:0] dt;
    logic [10:0] free;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = erbs_pkg::REG_EMISSION_RATE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    idle_on = 1'b1;
    hold_req = 0;
    tick_total = 0;
    setting_total = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // continuous emission at full rate: zero dt, empty pool, clamped pool
    set_config(32'hFFFF_FFFF, 11'd0, 24'd0);
    send_tick(24'd0, 11'd1024);
    send_tick(24'hFF_FFFF, 11'd0);
    send_tick(24'hFF_FFFF, 11'd2047);
    send_tick(24'd1, 11'd1024);
    send_tick(24'd1, 11'd1024);
    send_tick(24'h00_0100, 11'd5);
    drain();

    // first burst cut short, then many intervals in one tick
    set_config(32'h0000_8000, 11'd1024, 24'd1);
    send_tick(24'h01_0000, 11'd3);
    send_tick(24'h01_0000, 11'd1024);
    send_tick(24'hFF_FFFF, 11'd2047);
    send_tick(24'd0, 11'd1024);
    drain();

    // longest interval, single-spawn bursts
    set_config(32'd0, 11'd1, 24'hFF_FFFF);
    send_tick(24'hFF_FFFE, 11'd1024);
    send_tick(24'd1, 11'd1024);
    send_tick(24'hFF_FFFF, 11'd1024);
    send_tick(24'hFF_FFFF, 11'd0);
    send_tick(24'd0, 11'd0);
    drain();

    // burst count above pool size, shared slots between both sources
    set_config(32'h0001_0000, 11'd2047, 24'h00_8000);
    send_tick(24'h01_8000, 11'd1024);
    send_tick(24'h00_4000, 11'd2047);
    send_tick(24'h00_4000, 11'd10);
    send_tick(24'h00_4000, 11'd1);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: rate = '0;
        1: rate = 32'hFFFF_FFFF;
        2: rate = $urandom_range(1, 32'h0010_0000);
        3: rate = $urandom;
        default: rate = $urandom_range(32'h0001_0000, 32'h0400_0000);
      endcase
      case ($urandom_range(0, 5))
        0: count = '0;
        1: count = 11'd1;
        2: count = 11'd1024;
        3: count = 11'd2047;
        4: count = 11'($urandom_range(1, 16));
        default: count = 11'($urandom_range(0, 1024));
      endcase
      case ($urandom_range(0, 4))
        0: interval = '0;
        1: interval = 24'd1;
        2: interval = 24'hFF_FFFF;
        3: interval = 24'($urandom_range(1, 32'h0001_0000));
        default: interval = 24'($urandom);
      endcase
      set_config(rate, count, interval);
      idle_on <= (ph % 3 != 1);
      if (ph == 2) hold_req <= hold_req + 1;
      repeat (RAND_TICKS) begin
        case ($urandom_range(0, 9))
          0: dt = '0;
          1: dt = 24'hFF_FFFF;
          2, 3, 4: dt = 24'($urandom_range(1, 256));
          5, 6: dt = 24'($urandom_range(0, 32'h0001_0000));
          default: dt = 24'($urandom);
        endcase
        case ($urandom_range(0, 8))
          0: free = '0;
          1: free = 11'd1024;
          2: free = 11'd2047;
          3: free = 11'($urandom_range(0, 8));
          4: free = 11'($urandom);
          default: free = 11'($urandom_range(0, 1024));
        endcase
        send_tick(dt, free);
      end
      drain();
    end

    $display("Summary: %0d ticks under %0d register settings, %0d results checked",
             tick_total, setting_total, checked);
    $display("Covered rate and burst grants, pool exhaustion, slot clamping, output stalls");
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/erbs_pkg.sv
hdl/erbs_seq.sv
hdl/erbs_dp.sv
hdl/emission_rate_burst_spawner_unit.sv
tb/spawn_grant_checker.sv
tb/emission_rate_burst_spawner_unit_tb.sv
